// ===== hw/rtl/linear_recurrence_mod_matrix_power_core_macros.svh =====
// Assertion macros shared by the checker of the matrix-power core.
// Each use expects clk and rst_n in scope; no other dependencies.
`ifndef LINEAR_RECURRENCE_MOD_MATRIX_POWER_CORE_MACROS_SVH
`define LINEAR_RECURRENCE_MOD_MATRIX_POWER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset
`define LRMP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrmp: same-cycle check failed");

// Next-cycle implication, disabled in reset
`define LRMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrmp: next-cycle check failed");

`endif

// ===== hw/rtl/lrmp_pkg.sv =====
// Types, constants and small tables for the pentanacci matrix-power core.
// No dependencies; used by lrmp_cell, the top level and the checker.
package lrmp_pkg;

    localparam int Dim = 5;

    typedef logic [19:0] elem_t;
    typedef logic [2:0]  idx_t;
    typedef logic [1:0]  mode_t;

    // Modulus and Barrett constant floor(2^40 / p)
    localparam elem_t       PRIME      = 20'd1000003;
    localparam logic [20:0] BARRETT_MU = 21'd1099508;

    localparam idx_t LAST_IDX = 3'd4;

    // Right-hand operand of the current product
    localparam mode_t MODE_SQR  = 2'd0;
    localparam mode_t MODE_MUL  = 2'd1;
    localparam mode_t MODE_SEED = 2'd2;

    // Token handed from cell to cell: one element of the left matrix
    typedef struct packed {
        logic  valid;
        idx_t  row;
        idx_t  k;
        elem_t a;
    } tok_t;

    // Finished dot product leaving a cell
    typedef struct packed {
        logic  valid;
        idx_t  row;
        elem_t value;
    } cres_t;

    // Companion matrix: first row all ones, ones on the subdiagonal
    function automatic elem_t comp_elem(input idx_t r, input idx_t c);
        comp_elem = ((r == 3'd0) || (r == c + 3'd1)) ? 20'd1 : 20'd0;
    endfunction

    // Seed vector (8,4,2,1,1)
    function automatic elem_t seed_elem(input idx_t k);
        unique case (k)
            3'd0:    seed_elem = 20'd8;
            3'd1:    seed_elem = 20'd4;
            3'd2:    seed_elem = 20'd2;
            default: seed_elem = 20'd1;
        endcase
    endfunction

    // Fixed starting terms f(0)..f(5)
    function automatic elem_t small_term(input idx_t n);
        unique case (n)
            3'd0:    small_term = 20'd0;
            3'd1:    small_term = 20'd1;
            3'd2:    small_term = 20'd1;
            3'd3:    small_term = 20'd2;
            3'd4:    small_term = 20'd4;
            default: small_term = 20'd8;
        endcase
    endfunction

    function automatic elem_t ident_elem(input idx_t r, input idx_t c);
        ident_elem = (r == c) ? 20'd1 : 20'd0;
    endfunction

endpackage

// ===== hw/rtl/linear_recurrence_mod_matrix_power_core.sv =====
// Pentanacci term f(n) mod 1000003 for a 64-bit index n. Pulse start while busy
// is low; done is high for exactly one cycle with term_value, and the result
// cannot be stalled. Indices 0..5 answer in the cycle after start.
// Larger indices run square-and-multiply over the bits of n-5 on a row of five
// modular MAC cells: leading zero bits are skipped, the first set bit loads the
// companion matrix directly, each later bit squares and then multiplies by the
// companion matrix when the bit is set, and a final pass multiplies by the seed
// vector. Each 5x5 product streams its 25 left-hand elements into the chain one
// per cycle, with the five cells doing five MACs per cycle.
// Depends on lrmp_pkg and lrmp_cell.
module linear_recurrence_mod_matrix_power_core
    import lrmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] term_index,
    output logic        done,
    output logic [19:0] term_value
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BIT  = 3'd1;
    localparam logic [2:0] ST_SQR  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SEED = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [63:0] ex_reg, ex_next;
    logic [5:0]  bit_reg, bit_next;
    logic        started_reg, started_next;
    mode_t       mode_reg, mode_next;
    logic        feed_reg, feed_next;
    idx_t        frow_reg, frow_next, fk_reg, fk_next;
    logic        pdone_reg, pdone_next;
    logic        done_reg, done_next;
    elem_t       value_reg, value_next;

    elem_t acc_reg [Dim][Dim];
    elem_t res_reg [Dim][Dim];

    logic  load_id, load_base, load_res, adv, start_prod;
    tok_t  tok [Dim+1];
    cres_t cres [Dim];
    elem_t b_sel [Dim];

    // Sequencer over exponent bits
    always_comb
    begin
        state_next   = state_reg;
        ex_next      = ex_reg;
        bit_next     = bit_reg;
        started_next = started_reg;
        mode_next    = mode_reg;
        done_next    = 1'b0;
        value_next   = value_reg;
        load_id      = 1'b0;
        load_base    = 1'b0;
        load_res     = 1'b0;
        adv          = 1'b0;
        start_prod   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (term_index < 64'd6)
                    begin
                        done_next  = 1'b1;
                        value_next = small_term(term_index[2:0]);
                    end
                    else
                    begin
                        ex_next      = term_index - 64'd5;
                        bit_next     = 6'd63;
                        started_next = 1'b0;
                        load_id      = 1'b1;
                        state_next   = ST_BIT;
                    end
                end
            end
            ST_BIT:
            begin
                if (started_reg)
                begin
                    start_prod = 1'b1;
                    mode_next  = MODE_SQR;
                    state_next = ST_SQR;
                end
                else
                begin
                    // identity times base is base: load it directly
                    if (ex_reg[63])
                    begin
                        load_base    = 1'b1;
                        started_next = 1'b1;
                    end
                    adv = 1'b1;
                end
            end
            ST_SQR:
            begin
                if (pdone_reg)
                begin
                    load_res = 1'b1;
                    if (ex_reg[63])
                    begin
                        start_prod = 1'b1;
                        mode_next  = MODE_MUL;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        adv = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                if (pdone_reg)
                begin
                    load_res = 1'b1;
                    adv      = 1'b1;
                end
            end
            ST_SEED:
            begin
                if (pdone_reg)
                begin
                    done_next  = 1'b1;
                    value_next = res_reg[0][0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Step to the next exponent bit, or finish with the seed pass
        if (adv)
        begin
            if (bit_reg == 6'd0)
            begin
                start_prod = 1'b1;
                mode_next  = MODE_SEED;
                state_next = ST_SEED;
            end
            else
            begin
                bit_next   = bit_reg - 6'd1;
                ex_next    = {ex_reg[62:0], 1'b0};
                state_next = ST_BIT;
            end
        end
    end

    // Feeder: streams the left matrix row by row into the chain
    always_comb
    begin
        feed_next = feed_reg;
        frow_next = frow_reg;
        fk_next   = fk_reg;
        if (start_prod)
        begin
            feed_next = 1'b1;
            frow_next = 3'd0;
            fk_next   = 3'd0;
        end
        else if (feed_reg)
        begin
            if (fk_reg == LAST_IDX)
            begin
                fk_next = 3'd0;
                if (frow_reg == LAST_IDX)
                begin
                    feed_next = 1'b0;
                end
                else
                begin
                    frow_next = frow_reg + 3'd1;
                end
            end
            else
            begin
                fk_next = fk_reg + 3'd1;
            end
        end
        // last cell finishing the last row closes the product
        pdone_next = cres[Dim-1].valid && (cres[Dim-1].row == LAST_IDX);
    end

    assign tok[0] = '{valid: feed_reg, row: frow_reg, k: fk_reg,
                      a: acc_reg[frow_reg][fk_reg]};

    // Cell chain with right-hand operand chosen per column
    for (genvar c = 0; c < Dim; c++)
    begin : g_cell
        always_comb
        begin
            unique case (mode_reg)
                MODE_SQR:  b_sel[c] = acc_reg[tok[c].k][c];
                MODE_MUL:  b_sel[c] = comp_elem(tok[c].k, 3'(c));
                default:   b_sel[c] = seed_elem(tok[c].k);
            endcase
        end

        lrmp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[c]),
            .b_in    (b_sel[c]),
            .tok_out (tok[c+1]),
            .res_out (cres[c])
        );
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            mode_reg    <= MODE_SQR;
            feed_reg    <= 1'b0;
            frow_reg    <= 3'd0;
            fk_reg      <= 3'd0;
            pdone_reg   <= 1'b0;
            done_reg    <= 1'b0;
            bit_reg     <= 6'd0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            mode_reg    <= mode_next;
            feed_reg    <= feed_next;
            frow_reg    <= frow_next;
            fk_reg      <= fk_next;
            pdone_reg   <= pdone_next;
            done_reg    <= done_next;
            bit_reg     <= bit_next;
        end
    end

    // Payload registers and matrices
    always_ff @(posedge clk)
    begin
        ex_reg    <= ex_next;
        value_reg <= value_next;
        for (int r = 0; r < Dim; r++)
        begin
            for (int c = 0; c < Dim; c++)
            begin
                if (load_id)
                begin
                    acc_reg[r][c] <= ident_elem(3'(r), 3'(c));
                end
                else if (load_base)
                begin
                    acc_reg[r][c] <= comp_elem(3'(r), 3'(c));
                end
                else if (load_res)
                begin
                    acc_reg[r][c] <= res_reg[r][c];
                end
            end
        end
        for (int c = 0; c < Dim; c++)
        begin
            if (cres[c].valid)
            begin
                res_reg[cres[c].row][c] <= cres[c].value;
            end
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign term_value = value_reg;

endmodule

// ===== hw/rtl/lrmp_cell.sv =====
// One cell of the product chain: modular multiply-accumulate for one column.
// Depends on lrmp_pkg.
module lrmp_cell
    import lrmp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  tok_t  tok_in,
    input  elem_t b_in,
    output tok_t  tok_out,
    output cres_t res_out
);

    logic        tok_v_reg;
    idx_t        tok_row_reg, tok_k_reg;
    elem_t       tok_a_reg;
    logic        s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, res_v_reg;
    idx_t        s1_row_reg, s2_row_reg, s3_row_reg, s4_row_reg, res_row_reg;
    idx_t        s1_k_reg, s2_k_reg, s3_k_reg, s4_k_reg;
    logic [39:0] s1_prod_reg, s2_prod_reg, s3_prod_reg;
    logic [41:0] s2_t_reg;
    logic [40:0] s3_qp_reg;
    elem_t       s4_red_reg, acc_reg;

    logic [41:0] t_next;
    logic [40:0] qp_next;
    logic [21:0] r0, r1, r2;
    logic [20:0] sum, sum_red;
    elem_t       acc_next;

    // Barrett quotient estimate, then remainder with two corrections
    always_comb
    begin
        t_next  = s1_prod_reg[39:19] * BARRETT_MU;
        qp_next = s2_t_reg[41:21] * PRIME;
        r0 = s3_prod_reg[21:0] - s3_qp_reg[21:0];
        r1 = (r0 >= {2'b00, PRIME}) ? r0 - {2'b00, PRIME} : r0;
        r2 = (r1 >= {2'b00, PRIME}) ? r1 - {2'b00, PRIME} : r1;
    end

    // Running dot product, restarted at k = 0
    always_comb
    begin
        sum     = {1'b0, acc_reg} + {1'b0, s4_red_reg};
        sum_red = (sum >= {1'b0, PRIME}) ? sum - {1'b0, PRIME} : sum;
        acc_next = (s4_k_reg == 3'd0) ? s4_red_reg : sum_red[19:0];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_v_reg <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            tok_v_reg <= tok_in.valid;
            s1_v_reg  <= tok_in.valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            res_v_reg <= s4_v_reg && (s4_k_reg == LAST_IDX);
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        tok_row_reg <= tok_in.row;
        tok_k_reg   <= tok_in.k;
        tok_a_reg   <= tok_in.a;

        s1_prod_reg <= tok_in.a * b_in;
        s1_row_reg  <= tok_in.row;
        s1_k_reg    <= tok_in.k;

        s2_t_reg    <= t_next;
        s2_prod_reg <= s1_prod_reg;
        s2_row_reg  <= s1_row_reg;
        s2_k_reg    <= s1_k_reg;

        s3_qp_reg   <= qp_next;
        s3_prod_reg <= s2_prod_reg;
        s3_row_reg  <= s2_row_reg;
        s3_k_reg    <= s2_k_reg;

        s4_red_reg  <= r2[19:0];
        s4_row_reg  <= s3_row_reg;
        s4_k_reg    <= s3_k_reg;

        if (s4_v_reg)
        begin
            acc_reg <= acc_next;
        end
        res_row_reg <= s4_row_reg;
    end

    assign tok_out = '{valid: tok_v_reg, row: tok_row_reg, k: tok_k_reg, a: tok_a_reg};
    assign res_out = '{valid: res_v_reg, row: res_row_reg, value: acc_reg};

endmodule

// ===== hw/rtl/lrmp_checker.sv =====
// Port-level checker for the matrix-power core, bound to the top level.
// Depends on lrmp_pkg and the assertion macro header.
`include "linear_recurrence_mod_matrix_power_core_macros.svh"

module lrmp_checker
    import lrmp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [63:0] term_index,
    input logic        done,
    input logic [19:0] term_value
);

    // Result is always a reduced residue
    `LRMP_ASSERT_NOW(a_value_reduced, done, term_value < PRIME)

    // Small indices answer on the next cycle without going busy
    `LRMP_ASSERT_NEXT(a_small_fast, start && !busy && term_index < 64'd6, done && !busy)

    // Large indices go busy and give no result yet
    `LRMP_ASSERT_NEXT(a_large_busy, start && !busy && term_index >= 64'd6, busy && !done)

    // Leaving busy always delivers the transaction's result
    `LRMP_ASSERT_NOW(a_fall_done, $fell(busy), done)

endmodule

bind linear_recurrence_mod_matrix_power_core lrmp_checker u_lrmp_checker (.*);
